/* sv/htbd_pkg.sv */
// Shared types, character codes and decode functions for the hex text decoder.
// No dependencies; used by htbd_core, htbd_outbuf and the top level.
package htbd_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_UX      = 8'h58;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF_HEX  = 8'h66;
    localparam logic [7:0] CH_LX      = 8'h78;

    // Lookahead window: three pending characters plus the incoming one
    localparam int WIN     = 4;
    localparam int PEND    = 3;
    localparam int MAX_RES = 4;

    // One result word
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       no_data;
    } t_res;

    // All result words caused by one input word
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         nres;
    } t_batch;

    // One decision taken at the oldest character of a window
    typedef struct packed {
        logic       emit;
        logic [7:0] val;
        logic [2:0] used;
    } t_dec;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[CH_ZERO:CH_NINE]}) || (c inside {[CH_LA:CH_LF_HEX]})
            || (c inside {[CH_UA:CH_UF]});
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            t = c - CH_ZERO;
        end else if (c inside {[CH_UA:CH_UF]}) begin
            t = c - CH_UA + 8'd10;
        end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
            t = c - CH_LA + 8'd10;
        end
        return t[3:0];
    endfunction

    // First matching rule wins; missing characters are passed in as zero
    function automatic t_dec decide(input logic [7:0] a0, input logic [7:0] a1,
                                    input logic [7:0] a2, input logic [7:0] a3);
        t_dec d;
        d.emit = 1'b1;
        d.val  = CH_DOT;
        d.used = 3'd1;
        if ((a0 == CH_BSLASH || a0 == CH_ZERO) && (a1 == CH_LX || a1 == CH_UX)
            && is_hex(a2) && is_hex(a3)) begin
            d.val  = {nibble(a2), nibble(a3)};
            d.used = 3'd4;
        end else if (a0 == CH_PERCENT && is_hex(a1) && is_hex(a2)) begin
            d.val  = {nibble(a1), nibble(a2)};
            d.used = 3'd3;
        end else if (is_hex(a0) && is_hex(a1)) begin
            d.val  = {nibble(a0), nibble(a1)};
            d.used = 3'd2;
        end else if (a0 == CH_SPACE || a0 == CH_CR || a0 == CH_LF) begin
            d.emit = 1'b0;
            d.val  = 8'h00;
        end
        return d;
    endfunction

endpackage

/* sv/htbd_core.sv */
// Lookahead state and single-pass decode of one input word into a batch of results.
// Depends on htbd_pkg.
module htbd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    output htbd_pkg::t_batch      o_batch
);

    logic [7:0] r_pend [htbd_pkg::PEND];
    logic [7:0] n_pend [htbd_pkg::PEND];
    logic [1:0] r_cnt, n_cnt;
    logic       r_term, n_term;

    logic [7:0]     w   [htbd_pkg::WIN];
    htbd_pkg::t_dec dec [htbd_pkg::WIN];
    logic [2:0]     n_chars;
    logic           flush;

    // Build the window: pending characters, then the new one unless it is zero
    always_comb begin
        for (int i = 0; i < htbd_pkg::WIN; i++) begin
            if (3'(i) < {1'b0, r_cnt}) begin
                w[i] = r_pend[2'(i % htbd_pkg::PEND)];
            end else if (3'(i) == {1'b0, r_cnt} && i_char != htbd_pkg::CH_NUL) begin
                w[i] = i_char;
            end else begin
                w[i] = 8'h00;
            end
        end
        n_chars = {1'b0, r_cnt} + ((i_char != htbd_pkg::CH_NUL) ? 3'd1 : 3'd0);
        if (r_term) begin
            n_chars = 3'd0;
        end
        flush = i_last || (i_char == htbd_pkg::CH_NUL);
    end

    // Decide at every start position in parallel
    always_comb begin
        dec[0] = htbd_pkg::decide(w[0], w[1], w[2], w[3]);
        dec[1] = htbd_pkg::decide(w[1], w[2], w[3], 8'h00);
        dec[2] = htbd_pkg::decide(w[2], w[3], 8'h00, 8'h00);
        dec[3] = htbd_pkg::decide(w[3], 8'h00, 8'h00, 8'h00);
    end

    // Walk the decisions, collect results and work out the next state
    always_comb begin
        logic [2:0] pos;
        logic [2:0] idx;
        htbd_pkg::t_dec d;
        o_batch = '0;
        pos     = 3'd0;
        idx     = 3'd0;
        d       = '0;
        for (int s = 0; s < htbd_pkg::WIN; s++) begin
            if (pos < n_chars && (flush || (n_chars - pos) >= 3'd4)) begin
                d = dec[pos[1:0]];
                if (d.emit && o_batch.nres < 3'(htbd_pkg::MAX_RES)) begin
                    o_batch.res[o_batch.nres[1:0]] = '{data: d.val, eos: 1'b0,
                                                      no_data: 1'b0};
                    o_batch.nres = o_batch.nres + 3'd1;
                end
                pos = pos + d.used;
            end
        end
        if (pos > n_chars) begin
            pos = n_chars;
        end

        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_term = r_term;
        if (!r_term) begin
            n_cnt = 2'd0;
            if (!flush) begin
                for (int i = 0; i < htbd_pkg::PEND; i++) begin
                    idx = pos + 3'(i);
                    if (idx < 3'd4) begin
                        n_pend[i] = w[idx[1:0]];
                    end
                end
                n_cnt = 2'(n_chars - pos);
            end
            if (i_char == htbd_pkg::CH_NUL) begin
                n_term = 1'b1;
            end
        end

        // Mark the end of the string, or give a bare end marker
        if (i_last) begin
            if (o_batch.nres != 3'd0) begin
                o_batch.res[2'(o_batch.nres - 3'd1)].eos = 1'b1;
            end else begin
                o_batch.res[0] = '{data: 8'h00, eos: 1'b1, no_data: 1'b1};
                o_batch.nres   = 3'd1;
            end
            n_cnt  = 2'd0;
            n_term = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_term <= 1'b0;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_term <= n_term;
        end
    end

    // Lookahead characters
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

/* sv/htbd_outbuf.sv */
// Result register: holds the batch of one input word and hands it out one word a cycle
// while i_pop_ready is high. Depends on htbd_pkg.
module htbd_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  htbd_pkg::t_batch      i_batch,
    input  logic                  i_pop_ready,
    output logic                  o_load_ready,
    output logic                  o_valid,
    output htbd_pkg::t_res        o_res
);

    htbd_pkg::t_res [htbd_pkg::MAX_RES-1:0] r_buf;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_valid      = (r_cnt != 3'd0);
    assign o_res        = r_buf[0];
    assign pop          = o_valid && i_pop_ready;
    // Take a new batch when empty or once the last held word leaves in this cycle
    assign o_load_ready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_pop_ready);

    // Word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.nres;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // Load a batch or advance the shift line
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_batch.res;
        end else if (pop) begin
            for (int i = 0; i < htbd_pkg::MAX_RES - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

endmodule

/* sv/hex_text_to_byte_decoder.sv */
// Top level of the hex text decoder: input handshake, decode core and result register.
// Depends on htbd_pkg, htbd_core and htbd_outbuf.
//
// Usage:
//   s_axis carries one text character per word (tdata) with tlast marking the
//   final character of a string. m_axis returns decoded bytes in tdata, tlast
//   on the final result of a string, tuser set when the word is only an end
//   marker without data.
//   Escapes "\x", "\X", "0x", "0X" and "%" followed by two hex digits, and bare
//   hex pairs, decode to one byte; space, CR and LF are dropped; other
//   characters give '.'. A zero character ends the string until tlast.
//   Results of a word appear on m_axis in the cycle after it is taken.
//   Throughput while m_axis_tready is high: one character per cycle while each
//   word gives at most one result; a flush (zero character or tlast) gives up
//   to four results, sent one per cycle from the result register, and
//   s_axis_tready stays low until the last of them is taken. No word is dropped
//   while m_axis_tready is low; the result register holds and s_axis waits.
//   Reset (i_rst_n low, synchronous) clears the lookahead count, the
//   terminated flag and the word count of the result register.
module hex_text_to_byte_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] no_data
);

    logic             accept;
    htbd_pkg::t_batch batch;
    htbd_pkg::t_res   res;

    assign accept = s_axis_tvalid && s_axis_tready;

    htbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_batch  (batch)
    );

    htbd_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_batch      (batch),
        .i_pop_ready  (m_axis_tready),
        .o_load_ready (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_res        (res)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tlast = res.eos;
    assign m_axis_tuser = res.no_data;

endmodule

/* test/hex_decode_checker.sv */
`timescale 1ns / 100ps
// Checker for the hex text decoder: watches both stream channels, predicts the result
// words of every accepted character and compares them in order. Depends on htbd_pkg.
module hex_decode_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    input  logic       i_out_nodata,
    output int         o_pending,
    output int         o_errors,
    output int         o_checked
);

    // Predictor state: lookahead characters, their count, zero-seen flag
    logic [7:0] held_chars [3];
    int         held_cnt = 0;
    logic       stopped  = 1'b0;

    htbd_pkg::t_res expected_words[$];
    int             err_cnt     = 0;
    int             checked_cnt = 0;

    function automatic logic hex_digit(input logic [7:0] c);
        return (c >= htbd_pkg::CH_ZERO && c <= htbd_pkg::CH_NINE)
            || (c >= htbd_pkg::CH_LA && c <= htbd_pkg::CH_LF_HEX)
            || (c >= htbd_pkg::CH_UA && c <= htbd_pkg::CH_UF);
    endfunction

    // Only called on hex digits
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c <= htbd_pkg::CH_NINE) begin
            v = c - htbd_pkg::CH_ZERO;
        end else if (c >= htbd_pkg::CH_LA) begin
            v = c - htbd_pkg::CH_LA + 8'd10;
        end else begin
            v = c - htbd_pkg::CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

    // Decide at the oldest character; absent lookahead arrives as zero and never matches
    function automatic int classify(input logic [7:0] a0, input logic [7:0] a1,
                                    input logic [7:0] a2, input logic [7:0] a3,
                                    output logic emit, output logic [7:0] val);
        emit = 1'b1;
        val  = htbd_pkg::CH_DOT;
        if ((a0 == htbd_pkg::CH_BSLASH || a0 == htbd_pkg::CH_ZERO)
            && (a1 == htbd_pkg::CH_LX || a1 == htbd_pkg::CH_UX)
            && hex_digit(a2) && hex_digit(a3)) begin
            val = {digit_value(a2), digit_value(a3)};
            return 4;
        end
        if (a0 == htbd_pkg::CH_PERCENT && hex_digit(a1) && hex_digit(a2)) begin
            val = {digit_value(a1), digit_value(a2)};
            return 3;
        end
        if (hex_digit(a0) && hex_digit(a1)) begin
            val = {digit_value(a0), digit_value(a1)};
            return 2;
        end
        if (a0 == htbd_pkg::CH_SPACE || a0 == htbd_pkg::CH_CR || a0 == htbd_pkg::CH_LF) begin
            emit = 1'b0;
            val  = 8'h00;
        end
        return 1;
    endfunction

    // Queue the result words that one accepted character causes
    function automatic void predict_char(input logic [7:0] c, input logic lst);
        logic [7:0]     win [4];
        logic [7:0]     a [4];
        logic           flush;
        logic           emit;
        logic [7:0]     val;
        int             n;
        int             pos;
        int             used;
        int             nres;
        htbd_pkg::t_res w;
        nres = 0;
        if (!stopped) begin
            n = held_cnt;
            for (int i = 0; i < n; i++) win[i] = held_chars[i];
            if (c != htbd_pkg::CH_NUL) begin
                win[n] = c;
                n++;
            end
            flush = lst || (c == htbd_pkg::CH_NUL);
            pos   = 0;
            // Decide while four characters are at hand, or to the end on a flush
            while (pos < n && (flush || n - pos >= 4)) begin
                for (int i = 0; i < 4; i++) a[i] = (pos + i < n) ? win[pos + i] : 8'h00;
                used = classify(a[0], a[1], a[2], a[3], emit, val);
                if (emit) begin
                    w.data    = val;
                    w.eos     = 1'b0;
                    w.no_data = 1'b0;
                    expected_words.push_back(w);
                    nres++;
                end
                pos += used;
            end
            if (pos > n) pos = n;
            held_cnt = 0;
            if (!flush) begin
                for (int i = 0; pos + i < n; i++) held_chars[i] = win[pos + i];
                held_cnt = n - pos;
            end
            if (c == htbd_pkg::CH_NUL) stopped = 1'b1;
        end
        // Mark the final word of the string, or add a bare end marker
        if (lst) begin
            if (nres > 0) begin
                w = expected_words.pop_back();
                w.eos = 1'b1;
                expected_words.push_back(w);
            end else begin
                w.data    = 8'h00;
                w.eos     = 1'b1;
                w.no_data = 1'b1;
                expected_words.push_back(w);
            end
            held_cnt = 0;
            stopped  = 1'b0;
        end
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t ns: %s", $time, msg);
    endtask

    // Check output words first, then predict from the input word of this edge
    always @(posedge i_clk) begin
        htbd_pkg::t_res want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                checked_cnt++;
                if (expected_words.size() == 0) begin
                    flag_error($sformatf("unexpected word: byte %02h last %b nodata %b",
                                         i_out_byte, i_out_last, i_out_nodata));
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_byte !== want.data || i_out_last !== want.eos
                        || i_out_nodata !== want.no_data) begin
                        flag_error($sformatf(
                            "word %0d: expected byte %02h last %b nodata %b, got %02h %b %b",
                            checked_cnt, want.data, want.eos, want.no_data,
                            i_out_byte, i_out_last, i_out_nodata));
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_char(i_in_char, i_in_last);
        end
        o_pending <= expected_words.size();
        o_errors  <= err_cnt;
        o_checked <= checked_cnt;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the hex text decoder: clock, reset, text stimulus and verdict.
// Depends on htbd_pkg, hex_text_to_byte_decoder and hex_decode_checker.
module tb;

    typedef enum int {
        TK_ESC, TK_PCT, TK_PAIR, TK_BLANK, TK_NOISE, TK_BROKEN, TK_NUL
    } t_token_kind;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_char
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;           // [0] no_data

    int pending;
    int errors;
    int checked;

    logic [7:0] text[$];
    int         chars_sent   = 0;
    int         strings_sent = 0;
    bit         tx_calm      = 1'b0;

    hex_text_to_byte_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    hex_decode_checker decode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_char    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_byte   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_nodata (m_axis_tuser),
        .o_pending    (pending),
        .o_errors     (errors),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Timeout: %0d result words still expected", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return htbd_pkg::CH_ZERO + 8'(r);
        if (r < 16) return htbd_pkg::CH_LA + 8'(r - 10);
        return htbd_pkg::CH_UA + 8'(r - 16);
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Offer one word and hold it until taken; optionally wait for all results
    task automatic put_char(input logic [7:0] c, input logic lst, input bit drain);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
        gap = pick_gap(tx_calm);
        if (gap > 0 || drain) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (drain) begin
                do @(posedge i_clk); while (pending != 0);
            end
        end
    endtask

    // Send the buffered string with last on its final character
    task automatic send_text(input bit drain);
        for (int i = 0; i < text.size(); i++) begin
            put_char(text[i], i == text.size() - 1, drain && i == text.size() - 1);
        end
        text.delete();
        strings_sent++;
    endtask

    task automatic add_escape();
        case ($urandom_range(0, 3))
            0: begin
                text.push_back(htbd_pkg::CH_BSLASH);
                text.push_back(htbd_pkg::CH_LX);
            end
            1: begin
                text.push_back(htbd_pkg::CH_BSLASH);
                text.push_back(htbd_pkg::CH_UX);
            end
            2: begin
                text.push_back(htbd_pkg::CH_ZERO);
                text.push_back(htbd_pkg::CH_LX);
            end
            default: begin
                text.push_back(htbd_pkg::CH_ZERO);
                text.push_back(htbd_pkg::CH_UX);
            end
        endcase
    endtask

    task automatic add_token(input t_token_kind kind);
        case (kind)
            TK_ESC: begin
                add_escape();
                text.push_back(rand_hex());
                text.push_back(rand_hex());
            end
            TK_PCT: begin
                text.push_back(htbd_pkg::CH_PERCENT);
                text.push_back(rand_hex());
                text.push_back(rand_hex());
            end
            TK_PAIR: begin
                text.push_back(rand_hex());
                text.push_back(rand_hex());
            end
            TK_BLANK: begin
                case ($urandom_range(0, 2))
                    0:       text.push_back(htbd_pkg::CH_SPACE);
                    1:       text.push_back(htbd_pkg::CH_CR);
                    default: text.push_back(htbd_pkg::CH_LF);
                endcase
            end
            TK_NOISE: text.push_back(rand_plain());
            TK_BROKEN: begin
                // Cut an escape or a pair short and follow it with anything
                case ($urandom_range(0, 3))
                    0: add_escape();
                    1: begin add_escape(); text.push_back(rand_hex()); end
                    2: begin
                        text.push_back(htbd_pkg::CH_PERCENT);
                        text.push_back(rand_hex());
                    end
                    default: text.push_back(rand_hex());
                endcase
                text.push_back(rand_plain());
            end
            default: text.push_back(htbd_pkg::CH_NUL);
        endcase
    endtask

    function automatic t_token_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return TK_ESC;
        if (r < 38) return TK_PCT;
        if (r < 56) return TK_PAIR;
        if (r < 68) return TK_BLANK;
        if (r < 82) return TK_NOISE;
        if (r < 95) return TK_BROKEN;
        return TK_NUL;
    endfunction

    // Receiver: random stalls, calm stretches, and one long hold-off mid run
    initial begin
        int  hold;
        int  calm_left;
        bit  long_done;
        calm_left = 0;
        long_done = 1'b0;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!long_done && chars_sent >= 200) begin
                hold      = 300;
                long_done = 1'b1;
            end else if (calm_left > 0) begin
                hold = 0;
                calm_left--;
            end else begin
                hold = pick_gap(1'b0);
                if ($urandom_range(0, 15) == 0) calm_left = 30;
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        int ntok;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All rules, zero byte, CR and LF in one string
        text = '{htbd_pkg::CH_BSLASH, htbd_pkg::CH_LX, htbd_pkg::CH_UF,
                 htbd_pkg::CH_LF_HEX, htbd_pkg::CH_ZERO, htbd_pkg::CH_UX,
                 htbd_pkg::CH_ZERO, htbd_pkg::CH_LA, htbd_pkg::CH_PERCENT, 8'h65,
                 htbd_pkg::CH_NINE, htbd_pkg::CH_ZERO, htbd_pkg::CH_ZERO,
                 htbd_pkg::CH_SPACE, htbd_pkg::CH_CR, htbd_pkg::CH_LF};
        send_text(1'b0);
        // Escape cut short by the last flag
        text = '{htbd_pkg::CH_ZERO, htbd_pkg::CH_LX, 8'h34};
        send_text(1'b0);
        // Four unknown characters flushed at once, top code among them
        text = '{8'h71, 8'hFF, 8'h71, 8'h71};
        send_text(1'b0);
        // Zero ends the string; the rest is dropped and only an end marker follows
        text = '{htbd_pkg::CH_UA, htbd_pkg::CH_NUL, 8'h42};
        send_text(1'b1);
        // Zero together with the last flag on an empty lookahead
        text = '{htbd_pkg::CH_NUL};
        send_text(1'b0);
        // Only a dropped space: bare end marker
        text = '{htbd_pkg::CH_SPACE};
        send_text(1'b0);

        // Random strings, mostly well formed with noise and broken escapes mixed in
        while (chars_sent < 525) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            ntok    = $urandom_range(1, 8);
            for (int i = 0; i < ntok; i++) add_token(pick_kind());
            if ($urandom_range(0, 9) == 0) text.push_back(htbd_pkg::CH_NUL);
            send_text(strings_sent == 6 || $urandom_range(0, 11) == 0);
        end
        s_axis_tvalid <= 1'b0;

        // Let the remaining results drain before the verdict
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d characters in %0d strings; %0d result words compared.",
                 chars_sent, strings_sent, checked);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
